// File: sv/brle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row run-length encoder package
// Shared types and constants: register indexes, channel payloads and the
// bundle of results that one pixel produces.
// ----------------------------------------------------------------------------
package brle_pkg;

	localparam int CFG_W  = 13;	// width of a configuration register
	localparam int CNT_W  = 25;	// width of the image byte and light counters
	localparam int CODE_W = 8;	// width of one run code
	localparam int IDX_W  = 1;	// width of a register index
	localparam int MAX_RES = 3;	// most results one pixel can produce
	localparam int QDEPTH = 16;	// result queue depth
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic pixel_light;
	} pix_t;

	typedef struct packed {
		logic signed [CODE_W-1:0] code_byte;
		logic                     last;
		logic [CNT_W-1:0]         total_bytes;
		logic [CNT_W-1:0]         light_total;
	} res_t;

	// Results produced by one pixel, packed from entry 0 upward.
	typedef struct packed {
		logic [1:0]         cnt;
		res_t [MAX_RES-1:0] ent;
	} push_t;

endpackage

// File: sv/brle_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface brle_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/brle_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the image width and height, already limited to 1..MAX_SIDE.
// ----------------------------------------------------------------------------
module brle_cfg #(
	parameter int MAX_SIDE = 4096,
	parameter int SW       = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [brle_pkg::IDX_W-1:0]   cfg_index,
	input  logic [brle_pkg::CFG_W-1:0]   cfg_wdata,
	output logic [SW-1:0]                width_q,
	output logic [SW-1:0]                height_q
);
	import brle_pkg::*;

	logic [SW-1:0] lim_d;

	// Zero counts as one, anything above the maximum saturates.
	always_comb begin
		if (cfg_wdata == '0) begin
			lim_d = SW'(1);
		end else if (32'(cfg_wdata) > MAX_SIDE) begin
			lim_d = SW'(MAX_SIDE);
		end else begin
			lim_d = SW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(1);
			height_q <= SW'(1);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= lim_d;
				REG_IMAGE_HEIGHT: height_q <= lim_d;
				default: ;
			endcase
		end
	end
endmodule

// File: sv/brle_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run encoder core
// Registers each pixel, then closes runs, rows and images and packs the
// resulting codes into one bundle for the result queue.
// ----------------------------------------------------------------------------
module brle_core #(
	parameter int MAX_RUN = 127,
	parameter int RW      = 7,
	parameter int PW      = 12,
	parameter int SW      = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                room,
	input  logic [SW-1:0]       width_q,
	input  logic [SW-1:0]       height_q,
	brle_stream_if.sink         pixels,
	output brle_pkg::push_t     push
);
	import brle_pkg::*;

	logic             vld_s1;
	logic             pix_s1;

	logic [RW-1:0]    run_len_q;
	logic             run_light_q;
	logic [PW-1:0]    col_q;
	logic [PW-1:0]    row_q;
	logic [CNT_W-1:0] bytes_q;
	logic [CNT_W-1:0] light_q;

	logic             change;
	logic [RW-1:0]    len_next;
	logic [SW:0]      col_inc;
	logic [SW:0]      row_inc;
	logic             row_end;
	logic             img_end;
	logic             close;
	logic [CNT_W-1:0] bytes_next;
	logic [CNT_W-1:0] light_next;
	res_t             r_old;
	res_t             r_new;
	res_t             r_term;
	logic [1:0]       slot;

	function automatic logic signed [CODE_W-1:0] run_code(input logic light,
			input logic [RW-1:0] len);
		logic [CODE_W-1:0] mag;
		mag = CODE_W'(len);
		return light ? CODE_W'(-mag) : mag;
	endfunction

	assign pixels.ready = room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= pixels.valid && room;
		end
	end

	always_ff @(posedge clk) begin
		if (pixels.valid && room) begin
			pix_s1 <= pixels.data.pixel_light;
		end
	end

	always_comb begin
		change     = (run_len_q != '0) && (pix_s1 != run_light_q);
		len_next   = change ? RW'(1) : run_len_q + RW'(1);
		col_inc    = (SW+1)'(col_q) + (SW+1)'(1);
		row_inc    = (SW+1)'(row_q) + (SW+1)'(1);
		row_end    = col_inc >= {1'b0, width_q};
		img_end    = row_end && (row_inc >= {1'b0, height_q});
		close      = (len_next >= RW'(MAX_RUN)) || row_end;
		bytes_next = bytes_q + CNT_W'(change) + CNT_W'(close);
		light_next = light_q + CNT_W'(pix_s1);

		r_old  = '{code_byte: run_code(run_light_q, run_len_q), last: 1'b0,
			total_bytes: '0, light_total: '0};
		r_new  = '{code_byte: run_code(pix_s1, len_next), last: 1'b0,
			total_bytes: '0, light_total: '0};
		r_term = '{code_byte: '0, last: 1'b1,
			total_bytes: bytes_next + CNT_W'(1), light_total: light_next};

		push.ent = '0;
		slot     = 2'd0;
		if (change) begin
			push.ent[slot] = r_old;
			slot = slot + 2'd1;
		end
		if (close) begin
			push.ent[slot] = r_new;
			slot = slot + 2'd1;
		end
		if (img_end) begin
			push.ent[slot] = r_term;
			slot = slot + 2'd1;
		end
		push.cnt = vld_s1 ? slot : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q   <= '0;
			run_light_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			bytes_q     <= '0;
			light_q     <= '0;
		end else if (vld_s1) begin
			if (img_end) begin
				run_len_q   <= '0;
				run_light_q <= 1'b0;
				col_q       <= '0;
				row_q       <= '0;
				bytes_q     <= '0;
				light_q     <= '0;
			end else begin
				run_len_q   <= close ? '0 : len_next;
				run_light_q <= pix_s1;
				col_q       <= row_end ? '0 : PW'(col_inc);
				row_q       <= row_end ? PW'(row_inc) : row_q;
				bytes_q     <= bytes_next;
				light_q     <= light_next;
			end
		end
	end
endmodule

// File: sv/brle_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result queue
// Takes up to three results per cycle and hands out one per transaction.
// ----------------------------------------------------------------------------
module brle_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  brle_pkg::push_t push,
	output logic            room,
	brle_stream_if.source   codes
);
	import brle_pkg::*;

	res_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           rd;

	assign rd          = codes.valid && codes.ready;
	assign codes.valid = count_q != '0;
	assign codes.data  = mem_q[rd_ptr_q];
	// Space for the pixel in the input register and for one more.
	assign room        = count_q <= (QAW+1)'(QDEPTH - 2 * MAX_RES);

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.cnt) begin
				mem_q[wr_ptr_q + QAW'(i)] <= push.ent[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + QAW'(rd);
			count_q  <= count_q + (QAW+1)'(push.cnt) - (QAW+1)'(rd);
		end
	end
endmodule

// File: sv/binary_row_run_length_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary row run-length encoder
// Codes a two-colour raster image into signed run bytes, one row at a time.
// ----------------------------------------------------------------------------
// Pixels enter on the pixels channel in raster order, one per transaction,
// and the encoder takes one pixel every clock cycle as long as its result
// queue has room. Each row is cut into runs that end on a colour change, at
// MAX_RUN pixels, or at the end of the row; a run leaves on the codes channel
// as minus its length for light pixels and plus its length for dark pixels.
// After the last pixel of the image a zero code with last set carries the
// byte count (terminator included) and the light pixel count, and the next
// pixel starts a fresh image. A pixel is registered when it is taken and its
// codes are then written into the queue, from which the first code it causes
// can leave. One pixel can cause up to three codes while the output hands out
// at most one per cycle; the 16-entry queue absorbs these bursts, and a pixel
// is taken only while the queue holds at most ten codes. With the output always
// ready the sustained rate is one pixel per cycle as long as the pixels cause
// at most one code each on average. Very narrow or very small images cause more
// codes than pixels, and then the input is held back to the rate at which the
// output drains the codes. The user must write width and height through the
// plain register port only while the encoder is idle; the block does not
// enforce this. Zero reads as one and values above MAX_SIDE saturate.
// ----------------------------------------------------------------------------
module binary_row_run_length_encoder #(
	parameter int MAX_RUN  = 127,
	parameter int MAX_SIDE = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [brle_pkg::IDX_W-1:0] cfg_index,
	input  logic [brle_pkg::CFG_W-1:0] cfg_wdata,
	brle_stream_if.sink                pixels,
	brle_stream_if.source              codes
);
	import brle_pkg::*;

	// Run length counter, position counters and limit widths.
	localparam int RW = $clog2(MAX_RUN + 1);
	localparam int PW = $clog2(MAX_SIDE);
	localparam int SW = $clog2(MAX_SIDE + 1);

	logic [SW-1:0] width_q;
	logic [SW-1:0] height_q;
	logic          room;
	push_t         push;

	// Configuration registers, stored already limited.
	brle_cfg #(
		.MAX_SIDE (MAX_SIDE),
		.SW       (SW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.width_q   (width_q),
		.height_q  (height_q)
	);

	// Input register and the run, row and image logic.
	brle_core #(
		.MAX_RUN (MAX_RUN),
		.RW      (RW),
		.PW      (PW),
		.SW      (SW)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.room     (room),
		.width_q  (width_q),
		.height_q (height_q),
		.pixels   (pixels),
		.push     (push)
	);

	// Result queue that serializes the codes onto the output channel.
	brle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.codes  (codes)
	);

	// The terminator always carries a zero code.
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && codes.data.last |-> codes.data.code_byte == '0)
		else $error("terminator with a nonzero code");

	// A run code is never zero and carries no totals.
	a_run_code: assert property (@(posedge clk) disable iff (!arst_n)
		codes.valid && !codes.data.last |->
			codes.data.code_byte != '0 && codes.data.total_bytes == '0 &&
			codes.data.light_total == '0)
		else $error("malformed run code");

	// Three codes from one pixel happen only when that pixel ends the image.
	a_three_ends: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd3 |-> push.ent[2].last && !push.ent[1].last)
		else $error("three codes without an image end");

	// The core only pushes when the pixel was taken in the previous cycle.
	a_push_follows: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> $past(pixels.valid && pixels.ready))
		else $error("codes pushed without a pixel");
endmodule
